### rtl/sobel_edge_magnitude_rgb_top_assert.svh
// Assertion macros used by the checker file.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`define SEM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/sem_pkg.sv
`default_nettype none
package sem_pkg;
  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned PixW = 24;
  localparam logic [7:0] MagMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_item;
    logic       end_of_frame;
  } res_t;

  // Stencil for one channel over a 3x3 block; returns sum of squares.
  function automatic logic [20:0] sobel_sq(input logic [71:0] blk);
    logic signed [20:0] gx;
    logic signed [20:0] gy;
    logic signed [20:0] p [9];
    for (int k = 0; k < 9; k++) p[k] = {13'd0, blk[8*k +: 8]};
    gx = p[2] - p[0] + 21'sd2 * (p[5] - p[3]) + p[8] - p[6];
    gy = p[6] + 21'sd2 * p[7] + p[8] - p[0] - 21'sd2 * p[1] - p[2];
    sobel_sq = 21'(gx * gx) + 21'(gy * gy);
  endfunction
endpackage
`default_nettype wire

### rtl/sem_stream_if.sv
`default_nettype none
interface sem_stream_if #(parameter int unsigned W = 24) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/sem_mag_unit.sv
`default_nettype none
// Rounded integer square root, two result bits per cycle.
module sem_mag_unit
  import sem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [20:0] sq,
  output logic             done,
  output logic [7:0]       mag
);
  logic [21:0] rem_r, rem_nxt;
  logic [10:0] root_r, root_nxt;
  logic [23:0] src_r, src_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [21:0] r1, r2, t1, t2;
  logic [10:0] q1, q2;

  always_comb begin
    t1 = {rem_r[19:0], src_r[23:22]} - {9'd0, root_r, 2'b01};
    if (!t1[21]) begin
      r1 = t1; q1 = {root_r[9:0], 1'b1};
    end else begin
      r1 = {rem_r[19:0], src_r[23:22]}; q1 = {root_r[9:0], 1'b0};
    end
    t2 = {r1[19:0], src_r[21:20]} - {9'd0, q1, 2'b01};
    if (!t2[21]) begin
      r2 = t2; q2 = {q1[9:0], 1'b1};
    end else begin
      r2 = {r1[19:0], src_r[21:20]}; q2 = {q1[9:0], 1'b0};
    end
    rem_nxt = rem_r; root_nxt = root_r; src_nxt = src_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      rem_nxt = '0; root_nxt = '0; src_nxt = {3'd0, sq}; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = r2; root_nxt = q2; src_nxt = {src_r[19:0], 4'd0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd5) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    src_r  <= src_nxt;
  end

  logic [11:0] rnd;
  always_comb begin
    done = busy_r && !busy_nxt;
    // remainder > root rounds up
    rnd = {1'b0, q2} + {11'd0, (r2 > {11'd0, q2})};
    mag = (rnd > 12'd255) ? MagMax : rnd[7:0];
  end
endmodule
`default_nettype wire

### rtl/sobel_edge_magnitude_rgb_top.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Each
// accepted pixel is read against two line memories (registered reads),
// the window shifts, and then each result the pixel releases (zero to
// four) is computed by three square-root units, one per channel. No new
// pixel is taken until every result of the last one has been computed
// and taken by out_ready. Results for row y appear with pixel (y+1,x+1);
// the last row is flushed in the same pass. Writing image_width or
// image_height restarts the frame at row 0, column 0.
`default_nettype none
module sobel_edge_magnitude_rgb_top
  import sem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_red,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic                       out_last_of_item,
  output logic                       out_end_of_frame,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  sem_stream_if #(.W(PixW)) in_if (.clk(clk));
  sem_stream_if #(.W(26)) out_if (.clk(clk));
  assign in_if.valid = in_valid;
  assign in_if.data  = {in_blue, in_green, in_red};
  assign in_ready    = in_if.ready;
  assign out_valid   = out_if.valid;
  assign out_if.ready = out_ready;
  assign {out_red, out_green, out_blue, out_last_of_item, out_end_of_frame} = out_if.data;

  logic [WidthRegW-1:0]  width_r;
  logic [HeightRegW-1:0] height_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [12:0]           row_r, row_nxt;
  logic [PixW-1:0]       mem1 [MAX_WIDTH];
  logic [PixW-1:0]       mem2 [MAX_WIDTH];
  logic [PixW-1:0]       rd1_r, rd2_r, cur_r;
  logic [PixW-1:0]       win_r [9];
  state_t                st_r, st_nxt;
  logic [CW-1:0]         c_r, w_eff;
  logic [12:0]           r_r, h_eff;
  logic [3:0]            plan_r;
  logic [1:0]            sel_r;
  logic                  start_r;
  logic                  obuf_v_r;
  res_t                  obuf_r;
  logic                  dn0, dn1, dn2;
  logic [7:0]            m0, m1, m2;
  logic [71:0]           blk [3];
  logic [1:0]            dr, dc;

  always_comb begin
    if (width_r == '0) w_eff = CW'(1);
    else if (32'(width_r) > MAX_WIDTH)
      w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
    if (height_r == '0) h_eff = 13'd1;
    else if (height_r > 13'(HeightLimit)) h_eff = 13'(HeightLimit);
    else h_eff = 13'(height_r - 13'd0);
  end

  wire acc = in_valid && in_if.ready;
  assign in_if.ready = (st_r == ST_IDLE) && !cfg_we;

  always_comb begin
    col_nxt = col_r; row_nxt = row_r;
    if (acc) begin
      if (col_r + CW'(1) >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_r + 13'd1 >= h_eff) ? 13'd0 : row_r + 13'd1;
      end else col_nxt = col_r + CW'(1);
    end
    if (cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
      col_nxt = '0; row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd1_r <= mem1[col_r[AW-1:0]];
      rd2_r <= mem2[col_r[AW-1:0]];
      cur_r <= in_if.data;
      mem1[col_r[AW-1:0]] <= in_if.data;
    end
    if (st_r == ST_FILL) mem2[c_r[AW-1:0]] <= rd1_r;
  end

  // emission plan bit order: (0,0),(0,1),(1,0),(1,1)
  logic [3:0] plan_w;
  always_comb begin
    plan_w[0] = (r_r >= 13'd1) && (c_r >= CW'(1));
    plan_w[1] = (r_r >= 13'd1) && (c_r == w_eff - CW'(1));
    plan_w[2] = (r_r == h_eff - 13'd1) && (c_r >= CW'(1));
    plan_w[3] = (r_r == h_eff - 13'd1) && (c_r == w_eff - CW'(1));
  end

  logic [1:0] nxt_sel;
  logic       have_nxt;
  always_comb begin
    have_nxt = 1'b0; nxt_sel = 2'd0;
    for (int k = 3; k >= 0; k--) if (plan_r[k]) begin have_nxt = 1'b1; nxt_sel = 2'(k); end
  end

  logic run_r;
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) st_nxt = ST_FILL;
      ST_FILL: st_nxt = ST_EMIT;
      ST_EMIT: if (!have_nxt && !run_r && !obuf_v_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  wire issue = (st_r == ST_EMIT) && have_nxt && !run_r && !obuf_v_r;
  wire mag_done = dn0 && dn1 && dn2;
  wire last_res = (plan_r == 4'd0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; col_r <= '0; row_r <= '0;
      width_r <= WidthRegW'(1024); height_r <= HeightRegW'(768);
      obuf_v_r <= 1'b0; run_r <= 1'b0; start_r <= 1'b0; plan_r <= '0; sel_r <= '0;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else begin
      st_r <= st_nxt; col_r <= col_nxt; row_r <= row_nxt;
      if (cfg_we && cfg_index == CFG_WIDTH) width_r <= cfg_data[WidthRegW-1:0];
      if (cfg_we && cfg_index == CFG_HEIGHT) height_r <= cfg_data[HeightRegW-1:0];
      start_r <= issue;
      if (acc) begin
        c_r <= col_r; r_r <= row_r;
      end
      if (st_r == ST_FILL) begin
        for (int i = 0; i < 3; i++) begin
          win_r[3*i]   <= (c_r == '0) ? '0 : win_r[3*i+1];
          win_r[3*i+1] <= (c_r == '0) ? '0 : win_r[3*i+2];
        end
        win_r[2] <= (r_r >= 13'd2) ? rd2_r : '0;
        win_r[5] <= (r_r >= 13'd1) ? rd1_r : '0;
        win_r[8] <= cur_r;
        plan_r <= plan_w;
      end
      if (issue) begin
        sel_r <= nxt_sel; run_r <= 1'b1;
        plan_r[nxt_sel] <= 1'b0;
      end
      if (mag_done) begin
        run_r <= 1'b0; obuf_v_r <= 1'b1;
        obuf_r <= '{red: m0, green: m1, blue: m2, last_of_item: last_res,
                    end_of_frame: (sel_r == 2'd3)};
      end
      if (obuf_v_r && out_ready) obuf_v_r <= 1'b0;
    end
  end

  always_comb begin
    dr = {1'b0, sel_r[1]}; dc = {1'b0, sel_r[0]};
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          blk[ch][8*(3*i+j) +: 8] = (i + dr < 3 && j + dc < 3) ?
            win_r[3*(i+dr)+(j+dc)][8*ch +: 8] : 8'd0;
    end
  end

  sem_mag_unit u_mag_r (.clk, .rst_n, .start(start_r), .sq(sobel_sq(blk[0])), .done(dn0), .mag(m0));
  sem_mag_unit u_mag_g (.clk, .rst_n, .start(start_r), .sq(sobel_sq(blk[1])), .done(dn1), .mag(m1));
  sem_mag_unit u_mag_b (.clk, .rst_n, .start(start_r), .sq(sobel_sq(blk[2])), .done(dn2), .mag(m2));

  assign out_if.valid = obuf_v_r;
  assign out_if.data  = obuf_r;
endmodule
`default_nettype wire

### rtl/sem_checker.sv
`default_nettype none
`include "sobel_edge_magnitude_rgb_top_assert.svh"
module sem_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_of_item,
  input wire logic out_end_of_frame
);
  `SEM_ASSERT_IMPL(a_eof_last, clk, rst_n, out_valid && out_end_of_frame, out_last_of_item, "eof without last")
  `SEM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `SEM_ASSERT_IMPL(a_no_rdy_busy, clk, rst_n, out_valid, !in_ready, "request taken while result pending")
  `SEM_ASSERT_NEXT(a_cfg_block, clk, rst_n, in_valid && in_ready, !in_ready, "back to back request")
endmodule
bind sobel_edge_magnitude_rgb_top sem_checker u_sem_checker (.*);
`default_nettype wire
